[rtl/core/dda_pkg.sv]
// Shared types and constants for the DDA line rasterizer.
// No dependencies; every other file in rtl/core imports this package.
package dda_pkg;

   // Coordinate and fixed-point geometry
   localparam int COORD_BITS   = 10;
   localparam int FRAC_BITS    = 16;
   localparam int POS_BITS     = COORD_BITS + FRAC_BITS;
   localparam int INC_BITS     = POS_BITS + 1;
   localparam int LEFT_BITS    = COORD_BITS + 1;

   // Bit-serial divider: one quotient bit per cycle over the whole numerator
   localparam int DIV_STEPS    = POS_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   // Request word codes
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   typedef struct packed {
      logic                  req_type;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
   } dda_req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic                  last_pixel;
   } dda_rsp_type;

   // Controller -> datapath commands
   typedef struct packed {
      logic load;      // capture endpoints, start position and divider operands
      logic div_step;  // one restoring-division iteration on both axes
      logic div_fin;   // turn quotients into signed increments
      logic pixel;     // emit current pixel and advance
   } dda_cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic last;      // pixel counter at one (or zero): current pixel ends the line
   } dda_status_type;

endpackage

[rtl/core/dda_datapath.sv]
// Datapath of the DDA line rasterizer: endpoint math, bit-serial divider,
// position accumulators, pixel counter and the result register. Uses dda_pkg.
module dda_datapath
   import dda_pkg::*;
(
   input  logic           clock,
   input  dda_req_type    req_data,
   input  dda_cmd_type    cmd,
   output dda_status_type status,
   output dda_rsp_type    rsp_data
);

   // One restoring-division iteration: returns {remainder, shifted numerator/quotient}
   function automatic logic [COORD_BITS+POS_BITS-1:0] div_iter(
      input logic [COORD_BITS-1:0] rem,
      input logic [POS_BITS-1:0]   num,
      input logic [COORD_BITS-1:0] dvs
   );
      logic [COORD_BITS:0] sh;
      logic [COORD_BITS:0] diff;
      sh   = {rem, num[POS_BITS-1]};
      diff = sh - {1'b0, dvs};
      if (sh >= {1'b0, dvs}) begin
         return {diff[COORD_BITS-1:0], num[POS_BITS-2:0], 1'b1};
      end else begin
         return {sh[COORD_BITS-1:0], num[POS_BITS-2:0], 1'b0};
      end
   endfunction

   // Signed increment from the unsigned quotient; zero-length lines step by zero
   function automatic logic [INC_BITS-1:0] make_inc(
      input logic [POS_BITS-1:0] q,
      input logic                neg,
      input logic                zero
   );
      logic [INC_BITS-1:0] mag;
      mag = {1'b0, q};
      if (zero) begin
         return '0;
      end else if (neg) begin
         return -mag;
      end else begin
         return mag;
      end
   endfunction

   logic [COORD_BITS-1:0] adx;
   logic [COORD_BITS-1:0] ady;
   logic [COORD_BITS-1:0] step_len;

   logic [COORD_BITS-1:0] step_ff,  step_in;
   logic [COORD_BITS-1:0] rem_x_ff, rem_x_in;
   logic [COORD_BITS-1:0] rem_y_ff, rem_y_in;
   logic [POS_BITS-1:0]   num_x_ff, num_x_in;
   logic [POS_BITS-1:0]   num_y_ff, num_y_in;
   logic                  neg_x_ff, neg_x_in;
   logic                  neg_y_ff, neg_y_in;
   logic                  zero_ff,  zero_in;
   logic [INC_BITS-1:0]   inc_x_ff, inc_x_in;
   logic [INC_BITS-1:0]   inc_y_ff, inc_y_in;
   logic [POS_BITS-1:0]   pos_x_ff, pos_x_in;
   logic [POS_BITS-1:0]   pos_y_ff, pos_y_in;
   logic [LEFT_BITS-1:0]  left_ff,  left_in;
   dda_rsp_type           rsp_ff,   rsp_in;

   // Endpoint deltas and major-axis length
   assign adx = (req_data.end_x >= req_data.start_x) ? req_data.end_x - req_data.start_x
                                                     : req_data.start_x - req_data.end_x;
   assign ady = (req_data.end_y >= req_data.start_y) ? req_data.end_y - req_data.start_y
                                                     : req_data.start_y - req_data.end_y;
   assign step_len = (adx > ady) ? adx : ady;

   assign status.last = (left_ff <= LEFT_BITS'(1));
   assign rsp_data    = rsp_ff;

   // Next-state logic for all datapath registers
   always_comb begin
      step_in  = step_ff;
      rem_x_in = rem_x_ff;
      rem_y_in = rem_y_ff;
      num_x_in = num_x_ff;
      num_y_in = num_y_ff;
      neg_x_in = neg_x_ff;
      neg_y_in = neg_y_ff;
      zero_in  = zero_ff;
      inc_x_in = inc_x_ff;
      inc_y_in = inc_y_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      left_in  = left_ff;
      rsp_in   = rsp_ff;

      if (cmd.load) begin
         // numerator = |d| * 2^F + step/2, rounds the quotient to nearest
         step_in  = step_len;
         rem_x_in = '0;
         rem_y_in = '0;
         num_x_in = {adx, {FRAC_BITS{1'b0}}} + POS_BITS'(step_len >> 1);
         num_y_in = {ady, {FRAC_BITS{1'b0}}} + POS_BITS'(step_len >> 1);
         neg_x_in = req_data.start_x > req_data.end_x;
         neg_y_in = req_data.start_y > req_data.end_y;
         zero_in  = (step_len == '0);
         // start at the pixel center so truncation picks the nearest pixel
         pos_x_in = {req_data.start_x, 1'b1, {(FRAC_BITS-1){1'b0}}};
         pos_y_in = {req_data.start_y, 1'b1, {(FRAC_BITS-1){1'b0}}};
         left_in  = {1'b0, step_len} + LEFT_BITS'(1);
      end

      if (cmd.div_step) begin
         {rem_x_in, num_x_in} = div_iter(rem_x_ff, num_x_ff, step_ff);
         {rem_y_in, num_y_in} = div_iter(rem_y_ff, num_y_ff, step_ff);
      end

      if (cmd.div_fin) begin
         inc_x_in = make_inc(num_x_ff, neg_x_ff, zero_ff);
         inc_y_in = make_inc(num_y_ff, neg_y_ff, zero_ff);
      end

      // Emit truncated position, then advance (position wraps)
      if (cmd.pixel) begin
         rsp_in.pixel_x    = pos_x_ff[POS_BITS-1:FRAC_BITS];
         rsp_in.pixel_y    = pos_y_ff[POS_BITS-1:FRAC_BITS];
         rsp_in.last_pixel = status.last;
         pos_x_in = pos_x_ff + inc_x_ff[POS_BITS-1:0];
         pos_y_in = pos_y_ff + inc_y_ff[POS_BITS-1:0];
         left_in  = status.last ? '0 : left_ff - LEFT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      num_x_ff <= num_x_in;
      num_y_ff <= num_y_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
      zero_ff  <= zero_in;
      inc_x_ff <= inc_x_in;
      inc_y_ff <= inc_y_in;
      pos_x_ff <= pos_x_in;
      pos_y_ff <= pos_y_in;
      left_ff  <= left_in;
      rsp_ff   <= rsp_in;
   end

endmodule

[rtl/core/dda_ctrl.sv]
// Controller of the DDA line rasterizer: handshakes, divider sequencing,
// line-active flag and result valid. Uses dda_pkg; drives dda_datapath.
module dda_ctrl
   import dda_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_type,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  dda_status_type status,
   output dda_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff,   cnt_in;
   logic                    active_ff, active_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    req_fire;

   // Hold off new words while dividing or while the result slot is blocked
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // Datapath commands
   always_comb begin
      cmd.load     = req_fire && (req_type == REQ_LOAD);
      cmd.pixel    = req_fire && (req_type == REQ_PIXEL) && active_ff;
      cmd.div_step = (state_ff == ST_DIV);
      cmd.div_fin  = (state_ff == ST_FIN);
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_DIV;
               cnt_in   = '0;
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + DIV_CNT_BITS'(1);
            if (cnt_ff == DIV_CNT_BITS'(DIV_STEPS-1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Line-active flag and result valid
   always_comb begin
      active_in = active_ff;
      if (cmd.load) begin
         active_in = 1'b1;
      end else if (cmd.pixel && status.last) begin
         active_in = 1'b0;
      end
      rsp_valid_in = cmd.pixel || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/core/dda_line_rasterizer_top.sv]
// DDA line rasterizer, pulled one pixel per request word. A load word
// (req_type 0) takes the two endpoints; req_stall then stays high through
// the ST_DIV and ST_FIN states, while two bit-serial restoring dividers,
// one per axis, form the increments, one quotient bit per cycle. A pixel word
// (req_type 1) can be accepted every cycle while rsp_stall holds no result
// word; it returns the current pixel in the next cycle through a result
// register. While that result word sits under rsp_stall, req_stall stays
// high, and the next word is taken in the cycle the result word leaves. A
// line of length step returns step+1 pixels, the last flagged with
// last_pixel; pixel words while no line is active return nothing. A load
// while a line is active drops that line.
// Top level: instantiates dda_ctrl and dda_datapath; uses dda_pkg.
module dda_line_rasterizer_top
   import dda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dda_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dda_rsp_type rsp_data
);

   dda_cmd_type    cmd;
   dda_status_type status;

   dda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_data.req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dda_datapath u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

[rtl/core/dda_checker.sv]
// Port-level checker for dda_line_rasterizer_top, attached by bind below.
// Uses dda_pkg for the request word codes.
module dda_checker
   import dda_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input dda_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input dda_rsp_type rsp_data
);

   // Stalled result word stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped under stall");

   // Stalled result word does not change
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed under stall");

   // A load word starts the divider, which blocks the next request
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.req_type == REQ_LOAD) |=> req_stall)
      else $error("request accepted right after a load");

   // A result word appears only after an accepted pixel request
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && !req_stall && (req_data.req_type == REQ_PIXEL)))
      else $error("result without a pixel request");

endmodule

bind dda_line_rasterizer_top dda_checker u_dda_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[sim/tb_dda_line_rasterizer_top.sv]
// Self-checking testbench for dda_line_rasterizer_top: directed table, then random line traffic.
// Uses dda_pkg for the word types; an in-bench DDA tracker predicts the pixel words that no directed row types.
`timescale 1ns / 100ps

module tb_dda_line_rasterizer_top;
   import dda_pkg::*;

   localparam int ITEMS       = 1550;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = DIV_STEPS + 8;
   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

   // How a table row's outcome is known: tracker, typed "no pixel", typed pixel
   typedef enum {ROW_PRED, ROW_NONE, ROW_PIX} row_kind_type;

   typedef struct {
      dda_req_type  word;
      row_kind_type kind;
      dda_rsp_type  pix;
   } dir_row_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   dda_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   dda_rsp_type rsp_data;

   int unsigned snd_idle_pct = 28;
   int unsigned rcv_idle_pct = 71;
   int unsigned err_count    = 0;
   int unsigned words_taken  = 0;

   dda_rsp_type pending_pixels[$];

   // Tracker copy of the line walker state
   logic [POS_BITS-1:0]  trk_pos_x  = '0;
   logic [POS_BITS-1:0]  trk_pos_y  = '0;
   logic [INC_BITS-1:0]  trk_inc_x  = '0;
   logic [INC_BITS-1:0]  trk_inc_y  = '0;
   logic [LEFT_BITS-1:0] trk_left   = '0;
   logic                 trk_on     = 1'b0;

   dda_line_rasterizer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
   end

   // Signed per-axis increment d/len, rounded half away from zero
   function automatic logic [INC_BITS-1:0] axis_increment(input logic [COORD_BITS-1:0] a,
                                                          input logic [COORD_BITS-1:0] b,
                                                          input int unsigned len);
      longint unsigned mag, q;
      if (b >= a) mag = 64'(b - a);
      else mag = 64'(a - b);
      q = 0;
      if (len != 0) q = ((mag << FRAC_BITS) + (len >> 1)) / len;
      if (a > b) q = 0 - q;
      return q[INC_BITS-1:0];
   endfunction

   // Advance the tracker by one accepted word; live = word had an effect
   task automatic raster_step(input dda_req_type w, output bit has_px,
                              output dda_rsp_type px, output bit live);
      int unsigned adx, ady, len;
      has_px = 1'b0;
      px     = '0;
      live   = 1'b0;
      if (w.req_type == REQ_LOAD) begin
         adx = (w.end_x >= w.start_x) ? 32'(w.end_x - w.start_x) : 32'(w.start_x - w.end_x);
         ady = (w.end_y >= w.start_y) ? 32'(w.end_y - w.start_y) : 32'(w.start_y - w.end_y);
         len = (adx > ady) ? adx : ady;
         trk_inc_x = axis_increment(w.start_x, w.end_x, len);
         trk_inc_y = axis_increment(w.start_y, w.end_y, len);
         // start at coordinate + half a pixel
         trk_pos_x = {w.start_x, 1'b1, {(FRAC_BITS-1){1'b0}}};
         trk_pos_y = {w.start_y, 1'b1, {(FRAC_BITS-1){1'b0}}};
         trk_left  = LEFT_BITS'(len + 1);
         trk_on    = 1'b1;
         live      = 1'b1;
      end else if (trk_on) begin
         px.pixel_x    = trk_pos_x[POS_BITS-1 -: COORD_BITS];
         px.pixel_y    = trk_pos_y[POS_BITS-1 -: COORD_BITS];
         px.last_pixel = (trk_left <= 1);
         has_px        = 1'b1;
         live          = 1'b1;
         trk_pos_x     = trk_pos_x + trk_inc_x[POS_BITS-1:0];
         trk_pos_y     = trk_pos_y + trk_inc_y[POS_BITS-1:0];
         if (trk_left <= 1) begin
            trk_left = '0;
            trk_on   = 1'b0;
         end else begin
            trk_left = trk_left - 1'b1;
         end
      end
   endtask

   // Pixel request word; coordinates are don't-care, so fill them with noise
   function automatic dda_req_type pixel_word();
      dda_req_type w;
      w.req_type = REQ_PIXEL;
      w.start_x  = COORD_BITS'($urandom);
      w.start_y  = COORD_BITS'($urandom);
      w.end_x    = COORD_BITS'($urandom);
      w.end_y    = COORD_BITS'($urandom);
      return w;
   endfunction

   function automatic dir_row_type load_row(input int sx, input int sy, input int ex,
                                            input int ey);
      dir_row_type r;
      r.word.req_type = REQ_LOAD;
      r.word.start_x  = COORD_BITS'(sx);
      r.word.start_y  = COORD_BITS'(sy);
      r.word.end_x    = COORD_BITS'(ex);
      r.word.end_y    = COORD_BITS'(ey);
      r.kind          = ROW_NONE;
      r.pix           = '0;
      return r;
   endfunction

   function automatic dir_row_type pixel_row(input row_kind_type k, input int x, input int y,
                                             input bit fin);
      dir_row_type r;
      r.word           = pixel_word();
      r.kind           = k;
      r.pix.pixel_x    = COORD_BITS'(x);
      r.pix.pixel_y    = COORD_BITS'(y);
      r.pix.last_pixel = fin;
      return r;
   endfunction

   // Endpoint within lim of c, reflected back into the coordinate range
   function automatic logic [COORD_BITS-1:0] near_coord(input int c, input int lim);
      int off, v;
      off = $urandom_range(0, lim);
      v = $urandom_range(0, 1) ? c + off : c - off;
      if (v < 0 || v > COORD_MAX) v = 2 * c - v;
      if (v < 0 || v > COORD_MAX) v = $urandom_range(0, COORD_MAX);
      return v[COORD_BITS-1:0];
   endfunction

   // Send one word with random sender gaps; record what it should produce
   task automatic issue_word(input dda_req_type w, input row_kind_type kind,
                             input dda_rsp_type typed);
      logic [63:0] junk;
      bit          has_px, live;
      dda_rsp_type px;
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         junk = {$urandom, $urandom};
         req_valid <= 1'b0;
         req_data  <= junk[$bits(dda_req_type)-1:0];
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      raster_step(w, has_px, px, live);
      if (live) words_taken++;
      if (has_px && kind != ROW_NONE)
         pending_pixels = {pending_pixels, (kind == ROW_PIX) ? typed : px};
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Result checker
   always @(posedge clock) begin : pixel_checker
      dda_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel word with none pending: x=%0d y=%0d last=%0d",
                   rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.last_pixel);
            err_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.pixel_x !== want.pixel_x) begin
               $error("pixel_x: expected %0d, got %0d", want.pixel_x, rsp_data.pixel_x);
               err_count++;
            end
            if (rsp_data.pixel_y !== want.pixel_y) begin
               $error("pixel_y: expected %0d, got %0d", want.pixel_y, rsp_data.pixel_y);
               err_count++;
            end
            if (rsp_data.last_pixel !== want.last_pixel) begin
               $error("last_pixel: expected %0d, got %0d", want.last_pixel,
                      rsp_data.last_pixel);
               err_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      int unsigned cyc;
      cyc = 0;
      while (cyc < CYCLE_LIMIT) begin
         @(posedge clock);
         cyc++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      dir_row_type dir_rows[$];
      dda_req_type w;
      logic [63:0] raw;
      int          sx, sy, ex, ey, lim, npx, adx, ady, k, ph, phase;

      // Directed rows
      dir_rows = {dir_rows, pixel_row(ROW_NONE, 0, 0, 0)};      // request while idle
      dir_rows = {dir_rows, load_row(5, 5, 5, 5)};              // zero-length line
      dir_rows = {dir_rows, pixel_row(ROW_PIX, 5, 5, 1)};
      dir_rows = {dir_rows, pixel_row(ROW_NONE, 0, 0, 0)};      // back to idle
      dir_rows = {dir_rows, load_row(0, 0, COORD_MAX, COORD_MAX)};
      dir_rows = {dir_rows, pixel_row(ROW_PIX, 0, 0, 0)};
      dir_rows = {dir_rows, pixel_row(ROW_PIX, 1, 1, 0)};
      dir_rows = {dir_rows, load_row(COORD_MAX, COORD_MAX, 0, 0)}; // reload while active
      dir_rows = {dir_rows, pixel_row(ROW_PIX, COORD_MAX, COORD_MAX, 0)};
      dir_rows = {dir_rows, pixel_row(ROW_PIX, COORD_MAX - 1, COORD_MAX - 1, 0)};
      dir_rows = {dir_rows, load_row(COORD_MAX, 0, 0, 1)};      // shallow, x falling
      dir_rows = {dir_rows, pixel_row(ROW_PIX, COORD_MAX, 0, 0)};
      dir_rows = {dir_rows, pixel_row(ROW_PRED, 0, 0, 0)};
      dir_rows = {dir_rows, load_row(3, 10, 0, 0)};             // steep, both falling
      for (k = 0; k < 10; k++) dir_rows = {dir_rows, pixel_row(ROW_PRED, 0, 0, 0)};
      dir_rows = {dir_rows, pixel_row(ROW_PIX, 0, 0, 1)};
      dir_rows = {dir_rows, pixel_row(ROW_NONE, 0, 0, 0)};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) issue_word(dir_rows[i].word, dir_rows[i].kind, dir_rows[i].pix);

      // Random traffic, three idling phases
      phase = 0;
      while (words_taken < ITEMS) begin
         ph = (words_taken < ITEMS / 3) ? 0 : (words_taken < 2 * ITEMS / 3) ? 1 : 2;
         if (ph != phase) begin
            hold_until_drained();
            phase        = ph;
            snd_idle_pct = (ph == 1) ? 71 : 0;
            rcv_idle_pct = (ph == 1) ? 28 : 0;
         end
         if ($urandom_range(0, 99) < 88) begin
            // Well-formed line: load, then its pixels, sometimes cut short or overrun
            sx  = $urandom_range(0, COORD_MAX);
            sy  = $urandom_range(0, COORD_MAX);
            k   = $urandom_range(0, 99);
            lim = (k < 75) ? 12 : (k < 99) ? 60 : COORD_MAX;
            ex  = near_coord(sx, lim);
            ey  = near_coord(sy, lim);
            w.req_type = REQ_LOAD;
            w.start_x  = COORD_BITS'(sx);
            w.start_y  = COORD_BITS'(sy);
            w.end_x    = COORD_BITS'(ex);
            w.end_y    = COORD_BITS'(ey);
            issue_word(w, ROW_PRED, '0);
            adx = (ex > sx) ? ex - sx : sx - ex;
            ady = (ey > sy) ? ey - sy : sy - ey;
            npx = ((adx > ady) ? adx : ady) + 1;
            if ($urandom_range(0, 9) == 0) npx = $urandom_range(0, npx);
            else if ($urandom_range(0, 7) == 0) npx += $urandom_range(1, 2);
            for (k = 0; k < npx; k++) issue_word(pixel_word(), ROW_PRED, '0);
         end else begin
            // Raw noise word
            raw = {$urandom, $urandom};
            w   = raw[$bits(dda_req_type)-1:0];
            issue_word(w, ROW_PRED, '0);
         end
      end

      hold_until_drained();
      repeat (SETTLE) @(posedge clock);
      if (err_count == 0 && pending_pixels.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
